/* rtl/pbck_pkg.sv */
// Shared widths, register codes and configuration type for the pixel blend core.
package pbck_pkg;

  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned RGB_W      = 24;
  localparam int unsigned ALPHA_W    = 10;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_SHOWN = CFG_IDX_W'(3);

  // Alpha of minus one means opaque after reset.
  localparam logic signed [ALPHA_W-1:0] ALPHA_RESET = -10'sd1;

  typedef struct packed {
    logic signed [ALPHA_W-1:0] alpha;
    logic                      key_enable;
    logic [RGB_W-1:0]          key_color;
    logic                      surface_shown;
  } cfg_t;

endpackage

/* rtl/pbck_if.sv */
// Valid/ready channel interfaces for pixel beats, result beats and register writes.
interface pbck_in_if;
  import pbck_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] src_pixel;
  logic [PIXEL_W-1:0] dst_pixel;
  modport source (output valid, src_pixel, dst_pixel, input ready);
  modport sink (input valid, src_pixel, dst_pixel, output ready);
endinterface

interface pbck_out_if;
  import pbck_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] out_pixel;
  logic               write_enable;
  modport source (output valid, out_pixel, write_enable, input ready);
  modport sink (input valid, out_pixel, write_enable, output ready);
endinterface

interface pbck_cfg_if;
  import pbck_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pixel_blend_with_color_key_core.sv */
// Pixel blend with color key: input register, blend logic, result register.
// Throughput: one pixel pair per cycle while out_o.ready is high, set by the
// two-register pipeline with per-stage ready; the blend multipliers sit between the input
// and result registers. Reset (rst_ni low, asynchronous) empties both stages and sets
// alpha to -1, key_enable, key_color and surface_shown to 0.
module pixel_blend_with_color_key_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbck_cfg_if.sink  cfg_i,
  pbck_in_if.sink   in_i,
  pbck_out_if.source out_o
);
  import pbck_pkg::*;

  cfg_t               cfg;
  logic               in_valid_q;
  logic [PIXEL_W-1:0] src_q;
  logic [PIXEL_W-1:0] dst_q;
  logic               out_valid_q;
  logic [PIXEL_W-1:0] out_pixel_q;
  logic               write_enable_q;
  logic [PIXEL_W-1:0] out_pixel_d;
  logic               write_enable_d;
  logic               out_advance;
  logic               in_advance;

  pbck_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pbck_mix u_mix (
    .cfg_i          (cfg),
    .src_pixel_i    (src_q),
    .dst_pixel_i    (dst_q),
    .out_pixel_o    (out_pixel_d),
    .write_enable_o (write_enable_d)
  );

  // Each stage moves when it is empty or when its beat is taken by the stage or sink after it.
  assign out_advance = !out_valid_q || out_o.ready;
  assign in_advance  = !in_valid_q || out_advance;
  assign in_i.ready  = in_advance;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_advance) begin
        in_valid_q <= in_i.valid;
      end
      if (out_advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_advance && in_i.valid) begin
      src_q <= in_i.src_pixel;
      dst_q <= in_i.dst_pixel;
    end
    if (out_advance && in_valid_q) begin
      out_pixel_q    <= out_pixel_d;
      write_enable_q <= write_enable_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_pixel    = out_pixel_q;
  assign out_o.write_enable = write_enable_q;

endmodule

/* rtl/pbck_cfg_regs.sv */
// Configuration register file written through the register write channel.
module pbck_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  pbck_cfg_if.sink        cfg_i,
  output pbck_pkg::cfg_t  cfg_o
);
  import pbck_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  // Decode the register index of a write beat.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ALPHA:         cfg_d.alpha         = $signed(cfg_i.data[ALPHA_W-1:0]);
        CFG_KEY_ENABLE:    cfg_d.key_enable    = cfg_i.data[0];
        CFG_KEY_COLOR:     cfg_d.key_color     = cfg_i.data[RGB_W-1:0];
        CFG_SURFACE_SHOWN: cfg_d.surface_shown = cfg_i.data[0];
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha         <= ALPHA_RESET;
      cfg_q.key_enable    <= 1'b0;
      cfg_q.key_color     <= '0;
      cfg_q.surface_shown <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/pbck_mix.sv */
// Combinational blend, color key and write decision for one pixel pair.
module pbck_mix (
  input  pbck_pkg::cfg_t                cfg_i,
  input  logic [pbck_pkg::PIXEL_W-1:0]  src_pixel_i,
  input  logic [pbck_pkg::PIXEL_W-1:0]  dst_pixel_i,
  output logic [pbck_pkg::PIXEL_W-1:0]  out_pixel_o,
  output logic                          write_enable_o
);
  import pbck_pkg::*;

  // One color byte: d + (s - d) * a / 256, quotient truncated toward zero.
  function automatic logic [7:0] mix_byte(input logic [7:0] s, input logic [7:0] d,
                                          input logic [7:0] a);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [9:0]  quo;
    diff = $signed({1'b0, s}) - $signed({1'b0, d});
    prod = diff * $signed({1'b0, a});
    quo  = prod[17:8];
    if (prod[17] && (prod[7:0] != 8'd0)) begin
      quo = quo + 10'sd1;
    end
    return d + quo[7:0];
  endfunction

  logic       key_match;
  logic       blend_range;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  assign key_match   = cfg_i.key_enable && (src_pixel_i[RGB_W-1:0] == cfg_i.key_color);
  // Alpha 1..255: non-negative, below 256 and not zero.
  assign blend_range = !cfg_i.alpha[ALPHA_W-1] && !cfg_i.alpha[8]
                       && (cfg_i.alpha[7:0] != 8'd0);

  assign blue  = mix_byte(src_pixel_i[7:0],   dst_pixel_i[7:0],   cfg_i.alpha[7:0]);
  assign green = mix_byte(src_pixel_i[15:8],  dst_pixel_i[15:8],  cfg_i.alpha[7:0]);
  assign red   = mix_byte(src_pixel_i[23:16], dst_pixel_i[23:16], cfg_i.alpha[7:0]);

  // Select the new destination value.
  always_comb begin
    out_pixel_o    = dst_pixel_i;
    write_enable_o = 1'b0;
    if (cfg_i.surface_shown && (cfg_i.alpha != '0) && !key_match) begin
      write_enable_o = 1'b1;
      if (blend_range) begin
        out_pixel_o = {dst_pixel_i[31:24], red, green, blue};
      end else if (cfg_i.key_enable) begin
        out_pixel_o = {dst_pixel_i[31:24], src_pixel_i[RGB_W-1:0]};
      end else begin
        out_pixel_o = src_pixel_i;
      end
    end
  end

endmodule
